FILE: hw/rtl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared types and constants of the BAM header stream parser.
// ----------------------------------------------------------------------------
package bhp_pkg;

  // Number of magic bytes checked at the head of the stream.
  localparam int unsigned MAGIC_LEN = 4;

  // Reset value of the magic register: "BAM\1", first byte in bits 7:0.
  localparam logic [31:0] MAGIC_RESET = 32'h014D_4142;

  // Configuration register byte addresses.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_WORD = 3'd0;

  // Walker phase. Codes 0..6 double as the field kind of a consumed byte.
  typedef enum logic [3:0] {
    PH_MAGIC = 4'd0,
    PH_TLEN  = 4'd1,
    PH_TEXT  = 4'd2,
    PH_NREF  = 4'd3,
    PH_NLEN  = 4'd4,
    PH_NAME  = 4'd5,
    PH_RLEN  = 4'd6,
    PH_DONE  = 4'd7,
    PH_ERR   = 4'd8
  } bhp_phase_e;

  // Field kind reported for a byte that is not part of the header.
  localparam logic [2:0] KIND_NONE = 3'd7;

  // Per-byte result.
  typedef struct packed {
    logic       in_header;
    logic [2:0] field_kind;
    logic       header_done;
    logic       magic_error;
    logic [1:0] error_position;
  } bhp_result_t;

endpackage

FILE: hw/rtl/bhp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bhp_cfg_regs
// APB-style register file holding the expected magic word.
// ----------------------------------------------------------------------------
module bhp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bhp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [31:0]                    magic_word_o
);

  logic [31:0] magic_q;
  logic        sel_magic;
  logic        wr_en;

  // Word decode only: low two bits are the byte offset.
  assign sel_magic = (paddr[bhp_pkg::CFG_ADDR_W-1:2] ==
                      bhp_pkg::REG_MAGIC_WORD[bhp_pkg::CFG_ADDR_W-1:2]);
  assign wr_en     = psel && penable && pwrite && sel_magic;
  assign pready    = 1'b1;
  assign prdata    = sel_magic ? magic_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= bhp_pkg::MAGIC_RESET;
    end else if (wr_en) begin
      magic_q <= pwdata;
    end
  end

  assign magic_word_o = magic_q;

endmodule

FILE: hw/rtl/bhp_walker.sv
// ----------------------------------------------------------------------------
// bhp_walker
// Header walker: phase, counters and per-byte classification.
// ----------------------------------------------------------------------------
module bhp_walker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic [31:0]          magic_word_i,
  output bhp_pkg::bhp_result_t result_o
);

  bhp_pkg::bhp_phase_e phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] refs_q, refs_d;
  logic        err_q, err_d;

  logic [31:0] acc_word;
  logic        word_last;
  logic [7:0]  expect_byte;
  logic        magic_last;
  logic [31:0] skip_dec;
  logic [31:0] refs_dec;
  logic        consumed;

  // Little-endian word assembly
  assign acc_word    = acc_q | ({24'd0, data_byte_i} << {byte_idx_q, 3'b000});
  assign word_last   = (byte_idx_q == 2'd3);
  assign expect_byte = 8'(magic_word_i >> {byte_idx_q, 3'b000});
  assign magic_last  = ((3'(byte_idx_q) + 3'd1) >= 3'(bhp_pkg::MAGIC_LEN));
  assign skip_dec    = skip_q - 32'd1;
  assign refs_dec    = refs_q - 32'd1;

  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    acc_d      = acc_q;
    skip_d     = skip_q;
    refs_d     = refs_q;
    err_d      = err_q;
    consumed   = 1'b1;
    unique case (phase_q) inside
      bhp_pkg::PH_MAGIC: begin
        if (expect_byte != data_byte_i) begin
          err_d    = 1'b1;
          phase_d  = bhp_pkg::PH_ERR;
          consumed = 1'b0;
        end else if (magic_last) begin
          byte_idx_d = 2'd0;
          acc_d      = 32'd0;
          phase_d    = bhp_pkg::PH_TLEN;
        end else begin
          byte_idx_d = byte_idx_q + 2'd1;
        end
      end
      bhp_pkg::PH_TLEN, bhp_pkg::PH_NREF, bhp_pkg::PH_NLEN: begin
        if (word_last) begin
          byte_idx_d = 2'd0;
          acc_d      = 32'd0;
          if (phase_q == bhp_pkg::PH_NREF) begin
            refs_d  = acc_word;
            phase_d = (acc_word != 32'd0) ? bhp_pkg::PH_NLEN : bhp_pkg::PH_DONE;
          end else begin
            skip_d = acc_word;
            if (acc_word == 32'd0) begin
              phase_d = (phase_q == bhp_pkg::PH_TLEN) ? bhp_pkg::PH_NREF
                                                      : bhp_pkg::PH_RLEN;
            end else begin
              phase_d = (phase_q == bhp_pkg::PH_TLEN) ? bhp_pkg::PH_TEXT
                                                      : bhp_pkg::PH_NAME;
            end
          end
        end else begin
          acc_d      = acc_word;
          byte_idx_d = byte_idx_q + 2'd1;
        end
      end
      bhp_pkg::PH_TEXT: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_d = bhp_pkg::PH_NREF;
        end
      end
      bhp_pkg::PH_NAME: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_d = bhp_pkg::PH_RLEN;
        end
      end
      bhp_pkg::PH_RLEN: begin
        if (word_last) begin
          byte_idx_d = 2'd0;
          refs_d     = refs_dec;
          phase_d    = (refs_dec == 32'd0) ? bhp_pkg::PH_DONE : bhp_pkg::PH_NLEN;
        end else begin
          byte_idx_d = byte_idx_q + 2'd1;
        end
      end
      default: begin
        // done, error and unreachable codes: pass bytes through
        consumed = 1'b0;
      end
    endcase
  end

  always_comb begin
    result_o.in_header      = consumed;
    result_o.field_kind     = consumed ? phase_q[2:0] : bhp_pkg::KIND_NONE;
    result_o.header_done    = (phase_d == bhp_pkg::PH_DONE);
    result_o.magic_error    = err_d;
    result_o.error_position = err_d ? byte_idx_d : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= bhp_pkg::PH_MAGIC;
      byte_idx_q <= 2'd0;
      acc_q      <= 32'd0;
      skip_q     <= 32'd0;
      refs_q     <= 32'd0;
      err_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      acc_q      <= acc_d;
      skip_q     <= skip_d;
      refs_q     <= refs_d;
      err_q      <= err_d;
    end
  end

endmodule

FILE: hw/rtl/bam_header_stream_parser_top.sv
// ----------------------------------------------------------------------------
// bam_header_stream_parser_top
// Byte-serial walker of the BAM binary header with an APB magic register.
// ----------------------------------------------------------------------------
// Feed the BAM stream one byte per request on the data channel; every byte
// yields exactly one result request telling whether it belonged to the
// header, which header field it fell in (magic, text length, text, reference
// count, name length, name, reference length, or 7 for none), whether the
// header is complete (already set on its last byte), and a sticky magic
// error with the index of the first mismatching magic byte. The block takes
// one byte every cycle while results are taken. An accepted byte loads the
// input register, and the walker output for it moves into the result
// register, from which it is offered. Throughput is set by the single
// walker update per cycle; a stalled result holds the pipeline, nothing is
// dropped. The expected magic word (first byte in bits 7:0, reset "BAM\1")
// sits at byte address 0 of the APB port and should be written only while
// the stream is idle. After a magic error all bytes pass through unconsumed
// until reset.
// ----------------------------------------------------------------------------
module bam_header_stream_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bhp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,

  // Byte stream in
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     data_byte_i,

  // Per-byte results out
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           in_header_o,
  output logic [2:0]                     field_kind_o,
  output logic                           header_done_o,
  output logic                           magic_error_o,
  output logic [1:0]                     error_position_o
);

  logic [31:0] magic_word;

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Result register
  logic                 out_vld_q;
  bhp_pkg::bhp_result_t res_q;
  bhp_pkg::bhp_result_t res_d;

  logic advance;   // result register free or being drained
  logic step;      // walker consumes the held byte

  assign advance    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  bhp_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .magic_word_o (magic_word)
  );

  bhp_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .magic_word_i (magic_word),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign in_header_o      = res_q.in_header;
  assign field_kind_o     = res_q.field_kind;
  assign header_done_o    = res_q.header_done;
  assign magic_error_o    = res_q.magic_error;
  assign error_position_o = res_q.error_position;

endmodule
